// ===== src/gfkp_pkg.sv =====
// Package for the GTP-U flow key parser: the word types on both channels,
// the verdict codes and the fixed header offsets and field values.
// No dependencies.
`timescale 1ns / 1ps

package gfkp_pkg;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_UPLINK   = 2'd1,
    VERDICT_DOWNLINK = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] tunnel_id;
    logic [5:0]  flow_qfi;
    logic [31:0] ue_address;
    logic [31:0] remote_address;
    logic [15:0] ue_port;
    logic [15:0] peer_port;
    logic [7:0]  ip_proto;
    logic [31:0] key_hash;
  } out_word_t;

  localparam logic [15:0] TUNNEL_PORT_RESET = 16'd2152;

  // Byte offsets from the start of the Ethernet header.
  localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
  localparam logic [15:0] OFF_IHL      = 16'd14;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFF_SRC_FST  = 16'd26;
  localparam logic [15:0] OFF_SRC_LST  = 16'd29;
  localparam logic [15:0] OFF_DST_FST  = 16'd30;
  localparam logic [15:0] OFF_DST_LST  = 16'd33;
  localparam logic [16:0] MIN_PACKET   = 17'd34;
  localparam logic [6:0]  ETH_HDR_LEN  = 7'd14;
  localparam logic [5:0]  MIN_IP_HDR   = 6'd20;

  // Offsets from the start of the layer 4 header.
  localparam logic [15:0] REL_SPORT_LO = 16'd1;
  localparam logic [15:0] REL_DPORT_LO = 16'd3;
  localparam logic [15:0] REL_GTP_FLAG = 16'd8;
  localparam logic [15:0] REL_GTP_MSG  = 16'd9;
  localparam logic [15:0] REL_TEID_FST = 16'd12;
  localparam logic [15:0] REL_TEID_LST = 16'd15;
  localparam logic [15:0] REL_NEXT_EXT = 16'd19;
  localparam logic [6:0]  UDP_HDR_LEN  = 7'd8;
  localparam logic [6:0]  TCP_HDR_LEN  = 7'd20;
  localparam logic [6:0]  GTP_END      = 7'd20;
  localparam logic [6:0]  GTP_EXT_MIN  = 7'd24;

  localparam logic [7:0]  ETYPE_HI     = 8'h08;
  localparam logic [7:0]  ETYPE_LO     = 8'h00;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  MSG_GPDU     = 8'd255;
  localparam int          FLAG_EXT_BIT = 2;
  localparam logic [7:0]  EXT_PDU_SESS = 8'h85;
  localparam logic [15:0] EXT_QFI_REL  = 16'd2;
  localparam int          PORT_SHIFT   = 16;

endpackage

// ===== src/gtpu_flow_key_parser_core.sv =====
// Top level of the GTP-U flow key parser: byte-wide header parse with one
// key word per packet. Depends on gfkp_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data) carries one packet byte per
// word, starting at the Ethernet header, with last_byte set on the final byte.
// A word is taken at a clock edge where in_valid is high and in_stall is low.
// Every byte updates the parse state in the cycle it is taken, so one byte is
// taken per cycle while in_stall is low. The last byte of a packet produces
// one key word on the output channel (out_valid, out_stall, out_data), which
// is registered into the output register, or into the spare register while
// the receiver stalls a word. Other bytes produce nothing.
// The output has a two-word buffer. While the receiver stalls, a second key
// word is held in a spare register; in_stall rises only once that spare
// register is full, and falls when the receiver takes a word.
// The user writes the tunnel port register with cfg_write and cfg_data only
// while the block is idle; the block does not enforce this. Synchronous reset
// clears the parse state, empties the output buffer and loads the tunnel port with 2152.
module gtpu_flow_key_parser_core #(
  parameter int MAX_EXT_HEADERS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gfkp_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gfkp_pkg::out_word_t  out_data,
  input  logic                 cfg_write,
  input  logic [15:0]          cfg_data
);

  import gfkp_pkg::*;

  localparam int EW = $clog2(MAX_EXT_HEADERS + 1);

  logic [15:0]   tunnel_port;

  logic [15:0]   byte_offset, byte_offset_next;
  logic [5:0]    ip_header_bytes, ip_header_bytes_next;
  logic [7:0]    protocol_seen, protocol_seen_next;
  logic [31:0]   source_addr, source_addr_next;
  logic [31:0]   dest_addr, dest_addr_next;
  logic [15:0]   source_port_seen, source_port_seen_next;
  logic [15:0]   dest_port_seen, dest_port_seen_next;
  logic [31:0]   tunnel_id_seen, tunnel_id_seen_next;
  logic [15:0]   ext_start, ext_start_next;
  logic [7:0]    next_ext_type, next_ext_type_next;
  logic [EW-1:0] ext_visited, ext_visited_next;
  logic [5:0]    qfi_found, qfi_found_next;
  logic [15:0]   required_end, required_end_next;
  logic          rejected, rejected_next;
  logic          tunnel_path, tunnel_path_next;
  logic          walk_active, walk_active_next;
  logic [7:0]    cur_ext_len, cur_ext_len_next;

  out_word_t     spare_data;
  logic          spare_valid;

  logic          take;
  logic [7:0]    b;
  logic [15:0]   o;
  logic [6:0]    l4;
  logic [15:0]   rel;
  logic [15:0]   d;
  logic          need_en;
  logic [16:0]   need_end;
  logic [15:0]   need_sat;
  logic [16:0]   len;
  out_word_t     result;

  assign take     = in_valid && !in_stall;
  assign in_stall = spare_valid;
  assign b        = in_data.data_byte;
  assign o        = byte_offset;
  assign l4       = ETH_HDR_LEN + {1'b0, ip_header_bytes};
  assign rel      = o - {9'd0, l4};
  assign d        = o - ext_start;
  assign len      = {1'b0, o} + 17'd1;

  // Parse step for one byte. At most one end position is required per byte.
  always_comb begin
    ip_header_bytes_next  = ip_header_bytes;
    protocol_seen_next    = protocol_seen;
    source_addr_next      = source_addr;
    dest_addr_next        = dest_addr;
    source_port_seen_next = source_port_seen;
    dest_port_seen_next   = dest_port_seen;
    tunnel_id_seen_next   = tunnel_id_seen;
    ext_start_next        = ext_start;
    next_ext_type_next    = next_ext_type;
    ext_visited_next      = ext_visited;
    qfi_found_next        = qfi_found;
    rejected_next         = rejected;
    tunnel_path_next      = tunnel_path;
    walk_active_next      = walk_active;
    cur_ext_len_next      = cur_ext_len;
    need_en               = 1'b0;
    need_end              = '0;
    if (!rejected) begin
      priority if (o == OFF_ETYPE_HI) begin
        if (b != ETYPE_HI) rejected_next = 1'b1;
      end else if (o == OFF_ETYPE_LO) begin
        if (b != ETYPE_LO) rejected_next = 1'b1;
      end else if (o == OFF_IHL) begin
        ip_header_bytes_next = {b[3:0], 2'b00};
        if (ip_header_bytes_next < MIN_IP_HDR) begin
          rejected_next = 1'b1;
        end else begin
          need_en  = 1'b1;
          need_end = {10'd0, ETH_HDR_LEN + {1'b0, ip_header_bytes_next}};
        end
      end else if (o == OFF_PROTO) begin
        protocol_seen_next = b;
        if (b == PROTO_UDP) begin
          need_en  = 1'b1;
          need_end = {10'd0, l4 + UDP_HDR_LEN};
        end else if (b == PROTO_TCP) begin
          need_en  = 1'b1;
          need_end = {10'd0, l4 + TCP_HDR_LEN};
        end
      end else if (o >= OFF_SRC_FST && o <= OFF_SRC_LST) begin
        source_addr_next = {source_addr[23:0], b};
      end else if (o >= OFF_DST_FST && o <= OFF_DST_LST) begin
        dest_addr_next = {dest_addr[23:0], b};
      end else if (o >= {9'd0, l4}) begin
        priority if (rel <= REL_SPORT_LO) begin
          source_port_seen_next = {source_port_seen[7:0], b};
        end else if (rel <= REL_DPORT_LO) begin
          dest_port_seen_next = {dest_port_seen[7:0], b};
          if (rel == REL_DPORT_LO && protocol_seen == PROTO_UDP &&
              dest_port_seen_next == tunnel_port) begin
            tunnel_path_next = 1'b1;
            need_en          = 1'b1;
            need_end         = {10'd0, l4 + GTP_END};
          end
        end else if (tunnel_path) begin
          priority if (rel == REL_GTP_FLAG) begin
            if (!b[FLAG_EXT_BIT]) rejected_next = 1'b1;
          end else if (rel == REL_GTP_MSG) begin
            if (b != MSG_GPDU) rejected_next = 1'b1;
          end else if (rel >= REL_TEID_FST && rel <= REL_TEID_LST) begin
            tunnel_id_seen_next = {tunnel_id_seen[23:0], b};
          end else if (rel == REL_NEXT_EXT) begin
            if (b == 8'd0) begin
              rejected_next = 1'b1;
            end else begin
              next_ext_type_next = b;
              ext_start_next     = {9'd0, l4 + GTP_END};
              ext_visited_next   = '0;
              walk_active_next   = 1'b1;
              need_en            = 1'b1;
              need_end           = {10'd0, l4 + GTP_EXT_MIN};
            end
          end else if (rel > REL_NEXT_EXT && walk_active && o >= ext_start) begin
            // Extension walk: the length byte opens each extension, the
            // next-type byte closes it unless it is the session container.
            priority if (d == 16'd0) begin
              if (b == 8'd0) begin
                rejected_next = 1'b1;
              end else begin
                cur_ext_len_next = b;
                need_en          = 1'b1;
                need_end         = {1'b0, ext_start} + {7'd0, b, 2'b00};
              end
            end else if (next_ext_type == EXT_PDU_SESS) begin
              if (d == EXT_QFI_REL) begin
                if (b[5:0] == 6'd0) begin
                  rejected_next = 1'b1;
                end else begin
                  qfi_found_next   = b[5:0];
                  walk_active_next = 1'b0;
                end
              end
            end else if (d == {6'd0, {cur_ext_len, 2'b00} - 10'd1}) begin
              if (b == 8'd0 ||
                  {1'b0, ext_visited} + 1'b1 >= (EW + 1)'(MAX_EXT_HEADERS)) begin
                rejected_next = 1'b1;
              end else begin
                ext_visited_next   = ext_visited + 1'b1;
                next_ext_type_next = b;
                ext_start_next     = o + 16'd1;
                need_en            = 1'b1;
                need_end           = {1'b0, o} + 17'd5;
              end
            end else begin
              // Body bytes of an ordinary extension carry nothing.
            end
          end else begin
            // Other GTP-U header bytes and bytes after the walk are skipped.
          end
        end else begin
          // Layer 4 payload of a packet that is not tunnelled.
        end
      end else begin
        // Header bytes with no field of their own are only counted.
      end
    end
  end

  assign need_sat = need_end[16] ? 16'hffff : need_end[15:0];

  always_comb begin
    required_end_next = required_end;
    if (need_en && need_sat > required_end) required_end_next = need_sat;
    byte_offset_next = (byte_offset == 16'hffff) ? byte_offset : byte_offset + 16'd1;
  end

  // Key word for the packet that ends with this byte.
  always_comb begin
    result = '0;
    result.verdict = VERDICT_PASS;
    if (!rejected_next && len >= MIN_PACKET && len >= {1'b0, required_end_next}) begin
      if (tunnel_path_next) begin
        if (qfi_found_next != 6'd0) begin
          result.verdict   = VERDICT_UPLINK;
          result.tunnel_id = tunnel_id_seen_next;
          result.flow_qfi  = qfi_found_next;
          result.key_hash  = tunnel_id_seen_next ^ {26'd0, qfi_found_next};
        end
      end else begin
        result.verdict        = VERDICT_DOWNLINK;
        result.ue_address     = dest_addr_next;
        result.remote_address = source_addr_next;
        if (protocol_seen_next == PROTO_UDP || protocol_seen_next == PROTO_TCP) begin
          result.ue_port   = dest_port_seen_next;
          result.peer_port = source_port_seen_next;
        end
        result.ip_proto = protocol_seen_next;
        result.key_hash = dest_addr_next ^ source_addr_next ^
                          ({16'd0, result.ue_port} << PORT_SHIFT) ^
                          {16'd0, result.peer_port} ^ {24'd0, protocol_seen_next};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tunnel_port <= TUNNEL_PORT_RESET;
    end else if (cfg_write) begin
      tunnel_port <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_data.last_byte)) begin
      byte_offset      <= '0;
      ip_header_bytes  <= '0;
      protocol_seen    <= '0;
      source_addr      <= '0;
      dest_addr        <= '0;
      source_port_seen <= '0;
      dest_port_seen   <= '0;
      tunnel_id_seen   <= '0;
      ext_start        <= '0;
      next_ext_type    <= '0;
      ext_visited      <= '0;
      qfi_found        <= '0;
      required_end     <= '0;
      rejected         <= 1'b0;
      tunnel_path      <= 1'b0;
      walk_active      <= 1'b0;
      cur_ext_len      <= '0;
    end else if (take) begin
      byte_offset      <= byte_offset_next;
      ip_header_bytes  <= ip_header_bytes_next;
      protocol_seen    <= protocol_seen_next;
      source_addr      <= source_addr_next;
      dest_addr        <= dest_addr_next;
      source_port_seen <= source_port_seen_next;
      dest_port_seen   <= dest_port_seen_next;
      tunnel_id_seen   <= tunnel_id_seen_next;
      ext_start        <= ext_start_next;
      next_ext_type    <= next_ext_type_next;
      ext_visited      <= ext_visited_next;
      qfi_found        <= qfi_found_next;
      required_end     <= required_end_next;
      rejected         <= rejected_next;
      tunnel_path      <= tunnel_path_next;
      walk_active      <= walk_active_next;
      cur_ext_len      <= cur_ext_len_next;
    end
  end

  // Output register with a spare word behind it. A new key only arrives
  // while the spare register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (take && in_data.last_byte) begin
      if (out_valid && out_stall) begin
        spare_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      out_valid   <= spare_valid;
      spare_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.last_byte) begin
      if (out_valid && out_stall) begin
        spare_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (out_valid && !out_stall && spare_valid) begin
      out_data <= spare_data;
    end
  end

endmodule
